// ===== rtl/core/assert_macros.svh =====
// Assertion macros of the go-back-n sender window datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define GBN_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Implication checked in the same cycle.
`define GBN_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/gbn_pkg.sv =====
// Shared types, codes and constants of the go-back-n sender window.
package gbn_pkg;

	// Segment geometry (chunk size must be a power of two)
	localparam int CHUNK_BYTES = 512;
	localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
	localparam int BYTE_BITS   = 8;

	// Field widths
	localparam int SIZE_W  = 24;
	localparam int SEG_W   = 16;
	localparam int SEQ_W   = SEG_W + 1;
	localparam int WIN_W   = 5;
	localparam int RETRY_W = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 5;

	localparam int IN_DATA_W  = ((SIZE_W + SEG_W + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;
	localparam int OUT_DATA_W = ((SEG_W + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;

	localparam logic [WIN_W-1:0]   MAX_WINDOW      = WIN_W'(16);
	localparam logic [WIN_W-1:0]   WINDOW_RESET    = WIN_W'(10);
	localparam logic [RETRY_W-1:0] RETRIES_RESET   = RETRY_W'(10);
	localparam logic [RETRY_W-1:0] RETRY_SAT       = '1;
	localparam logic [SEG_W-1:0]   SEG_MAX         = '1;

	// Event codes
	typedef enum logic [1:0] {
		OP_START   = 2'd0,
		OP_ACK     = 2'd1,
		OP_TIMEOUT = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_FINAL = 2'd1,
		KIND_DONE  = 2'd2,
		KIND_ABORT = 2'd3
	} kind_t;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WINDOW_SIZE = 2'd0,
		REG_MAX_RETRIES = 2'd1
	} cfg_reg_t;

	// What an incoming event leads to
	typedef enum logic [1:0] {
		EV_NONE,
		EV_SEND,
		EV_FINISH
	} ev_class_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic emit_send;
		logic emit_fin;
	} gbn_cmd_t;

	// Datapath to controller
	typedef struct packed {
		ev_class_t ev;
		logic      can_send;
		logic      send_last;
		logic      out_free;
	} gbn_stat_t;

endpackage

// ===== rtl/core/gbn_cfg.sv =====
// Configuration registers: window size and retry limit.
module gbn_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gbn_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [gbn_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic [gbn_pkg::WIN_W-1:0]        win,
	output logic [gbn_pkg::RETRY_W-1:0]      retry_limit
);
	import gbn_pkg::*;

	logic [WIN_W-1:0]   window_q;
	logic [RETRY_W-1:0] retry_limit_q;

	assign cfg_ready = 1'b1;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q      <= WINDOW_RESET;
			retry_limit_q <= RETRIES_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WINDOW_SIZE: window_q      <= cfg_data[WIN_W-1:0];
				REG_MAX_RETRIES: retry_limit_q <= cfg_data[RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	// windows above the maximum act as the maximum
	assign win         = (window_q > MAX_WINDOW) ? MAX_WINDOW : window_q;
	assign retry_limit = retry_limit_q;

endmodule

// ===== rtl/core/gbn_ctrl.sv =====
// Controller: takes one event, then sequences its result beats.
module gbn_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  gbn_pkg::gbn_stat_t stat,
	output gbn_pkg::gbn_cmd_t  cmd
);
	import gbn_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEND,
		S_FIN
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == S_IDLE);

	// commands for the datapath
	always_comb begin
		cmd.take      = (state_q == S_IDLE) && s_tvalid;
		cmd.emit_send = (state_q == S_SEND) && stat.out_free && stat.can_send;
		cmd.emit_fin  = (state_q == S_FIN) && stat.out_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						case (stat.ev)
							EV_SEND:   state_q <= S_SEND;
							EV_FINISH: state_q <= S_FIN;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_SEND: begin
					// window closed or last send of this event
					if (stat.out_free && (!stat.can_send || stat.send_last)) begin
						state_q <= S_IDLE;
					end
				end
				S_FIN: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/gbn_dp.sv =====
// Datapath: window state, event decode, segment count and output register.
`include "assert_macros.svh"

module gbn_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [gbn_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [2:0]                      s_tuser,
	input  logic [gbn_pkg::WIN_W-1:0]       win,
	input  logic [gbn_pkg::RETRY_W-1:0]     retry_limit,
	input  gbn_pkg::gbn_cmd_t               cmd,
	output gbn_pkg::gbn_stat_t              stat,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [gbn_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [1:0]                      m_tuser,
	output logic                            m_tlast
);
	import gbn_pkg::*;

	localparam int SUM_W = SIZE_W + 1;

	// window state; base1 is the highest acked segment plus one
	logic [SEQ_W-1:0]   base1_q;
	logic [SEQ_W-1:0]   next_q;
	logic [SEG_W-1:0]   total_q;
	logic [RETRY_W-1:0] retry_q;
	logic               active_q;
	kind_t              fin_kind_q;

	// output register
	logic                  m_tvalid_q;
	logic [SEG_W-1:0]      seg_q;
	kind_t                 kind_q;
	logic                  last_q;

	// input fields
	op_t               op;
	logic              term;
	logic [SIZE_W-1:0] size;
	logic [SEG_W-1:0]  ackn;

	assign op   = op_t'(s_tuser[1:0]);
	assign term = s_tuser[2];
	assign size = s_tdata[SIZE_W-1:0];
	assign ackn = s_tdata[SIZE_W +: SEG_W];

	// segment count: ceiling of size over chunk, saturated
	logic [SUM_W-1:0] size_up;
	logic [SUM_W-1:0] segs_full;
	logic [SEG_W-1:0] segs;

	assign size_up   = {1'b0, size} + SUM_W'(CHUNK_BYTES - 1);
	assign segs_full = size_up >> CHUNK_SHIFT;
	assign segs      = (segs_full > SUM_W'(SEG_MAX)) ? SEG_MAX : segs_full[SEG_W-1:0];

	// ack handling: raise base, keep next at or above it
	logic [SEQ_W-1:0] ack1;
	logic [SEQ_W-1:0] base1_ack;
	logic [SEQ_W-1:0] next_ack;

	assign ack1      = {1'b0, ackn} + SEQ_W'(1);
	assign base1_ack = (ack1 > base1_q) ? ack1 : base1_q;
	assign next_ack  = (next_q < base1_ack) ? base1_ack : next_q;

	logic retry_out;
	assign retry_out = (retry_q >= retry_limit);

	// event classification
	ev_class_t ev_cls;

	always_comb begin
		case (op)
			OP_START:   ev_cls = EV_SEND;
			OP_ACK:     ev_cls = !active_q ? EV_NONE : (term ? EV_FINISH : EV_SEND);
			OP_TIMEOUT: ev_cls = !active_q ? EV_NONE : (retry_out ? EV_FINISH : EV_SEND);
			default:    ev_cls = EV_NONE;
		endcase
	end

	assign stat.ev = ev_cls;

	// send window check for the segment at next
	logic [SEQ_W-1:0] in_flight;
	logic             is_final;

	assign in_flight      = next_q - base1_q;
	assign is_final       = (next_q == {1'b0, total_q});
	assign stat.can_send  = (next_q <= {1'b0, total_q}) && (in_flight < SEQ_W'(win));
	assign stat.send_last = is_final || ((in_flight + SEQ_W'(1)) == SEQ_W'(win));
	assign stat.out_free  = !m_tvalid_q || m_tready;

	// window state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base1_q  <= '0;
			next_q   <= '0;
			total_q  <= '0;
			retry_q  <= '0;
			active_q <= 1'b0;
		end else if (cmd.take) begin
			case (op)
				OP_START: begin
					total_q  <= segs;
					base1_q  <= '0;
					next_q   <= '0;
					retry_q  <= '0;
					active_q <= 1'b1;
				end
				OP_ACK: begin
					if (active_q) begin
						retry_q <= '0;
						if (term) begin
							active_q <= 1'b0;
						end else begin
							base1_q <= base1_ack;
							next_q  <= next_ack;
						end
					end
				end
				OP_TIMEOUT: begin
					if (active_q) begin
						if (retry_out) begin
							active_q <= 1'b0;
						end else begin
							next_q <= base1_q;
							if (retry_q != RETRY_SAT) begin
								retry_q <= retry_q + RETRY_W'(1);
							end
						end
					end
				end
				default: ;
			endcase
		end else if (cmd.emit_send) begin
			next_q <= next_q + SEQ_W'(1);
		end
	end

	// finishing kind, latched with the event
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			fin_kind_q <= (op == OP_ACK) ? KIND_DONE : KIND_ABORT;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit_send || cmd.emit_fin) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.emit_send) begin
			seg_q  <= next_q[SEG_W-1:0];
			kind_q <= is_final ? KIND_FINAL : KIND_DATA;
			last_q <= stat.send_last;
		end else if (cmd.emit_fin) begin
			seg_q  <= '0;
			kind_q <= fin_kind_q;
			last_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DATA_W'(seg_q);
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	`GBN_ASSERT(a_next_not_below_base, next_q >= base1_q, "next segment below window base")
	`GBN_ASSERT(a_flight_bounded, (next_q - base1_q) <= SEQ_W'(MAX_WINDOW), "too many segments in flight")
	`GBN_ASSERT_IMPL(a_fin_is_last, m_tvalid_q && (kind_q == KIND_DONE || kind_q == KIND_ABORT), last_q, "done or abort beat without last")

endmodule

// ===== rtl/core/go_back_n_sender_window.sv =====
// Go-back-n sender window: an event is accepted only while no earlier one is in progress.
// Each event yields up to min(window_size, 16) send beats, one per cycle while not stalled,
// the first passing the controller state and then the output register; done and abort give a
// single beat. An ignored event leaves the controller idle; any other holds it busy until its
// beats are out, paced by the one-send-per-cycle sequencer and the single output register.
// arst_n clears the window state to idle and the registers to window 10, retries 10.
module go_back_n_sender_window (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gbn_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_data,
	// event stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [gbn_pkg::IN_DATA_W-1:0]   s_tdata,  // file_size[23:0], ack_number[39:24]
	input  logic [2:0]                      s_tuser,  // op[1:0], ack_terminal[2]
	// send order stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [gbn_pkg::OUT_DATA_W-1:0]  m_tdata,  // segment_number[15:0]
	output logic [1:0]                      m_tuser,  // kind[1:0]
	output logic                            m_tlast
);
	import gbn_pkg::*;

	logic [WIN_W-1:0]   win;
	logic [RETRY_W-1:0] retry_limit;
	gbn_cmd_t           cmd;
	gbn_stat_t          stat;

	gbn_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.win         (win),
		.retry_limit (retry_limit)
	);

	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gbn_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.win         (win),
		.retry_limit (retry_limit),
		.cmd         (cmd),
		.stat        (stat),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the go-back-n sender window, with its own window predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gbn_pkg::*;

	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 42;
	localparam int SETTLE_CYCLES = 12;
	localparam int QUIET_LIMIT   = 200000;
	localparam int PRINT_LIMIT   = 100;

	// Window and retry settings of the random phases but the last, phase 0 in the low bits
	localparam logic [PHASES*CFG_DATA_W-1:0] WIN_PLAN   = {5'd0, 5'd7, 5'd0, 5'd31, 5'd16, 5'd1};
	localparam logic [PHASES*CFG_DATA_W-1:0] RETRY_PLAN = {5'd0, 5'd31, 5'd3, 5'd0, 5'd15, 5'd1};

	// Receiver stall behaviour
	typedef enum logic [1:0] {
		RX_FREE,
		RX_RANDOM,
		RX_PERIODIC
	} rx_mode_t;

	typedef struct {
		op_t               op;
		logic [SIZE_W-1:0] size;
		logic [SEG_W-1:0]  ack;
		logic              term;
	} net_evt_t;

	typedef struct {
		kind_t            kind;
		logic [SEG_W-1:0] seg;
		logic             is_last;
	} send_order_t;

	// Clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #10 clk = ~clk;

	// DUT inputs, known from time zero
	logic                   cfg_valid = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic [IN_DATA_W-1:0]   s_tdata   = '0;
	logic [2:0]             s_tuser   = '0;
	logic                   m_tready  = 1'b0;

	logic                   cfg_ready;
	logic                   s_tready;
	logic                   m_tvalid;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic [1:0]             m_tuser;
	logic                   m_tlast;

	go_back_n_sender_window dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// Predicted window state and register copies
	logic [WIN_W-1:0]          cfg_window      = WINDOW_RESET;
	logic [RETRY_W-1:0]        cfg_max_retries = RETRIES_RESET;
	logic signed [SEQ_W:0]     sw_base         = '1;
	logic signed [SEQ_W:0]     sw_next         = '0;
	logic [SEG_W-1:0]          sw_total        = '0;
	logic [RETRY_W-1:0]        sw_retries      = '0;
	logic                      sw_active       = 1'b0;

	net_evt_t    event_q[$];
	send_order_t step_orders[$];
	send_order_t pending_orders[$];
	int          fail_count = 0;

	task report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function void push_order(kind_t kind, int seg);
		send_order_t o;
		o.kind    = kind;
		o.seg     = SEG_W'(seg);
		o.is_last = 1'b0;
		step_orders.push_back(o);
	endfunction

	// Send whatever the window allows, never past the final segment
	function void emit_window();
		int win;
		int base;
		int nxt;
		int total;
		win   = (cfg_window > MAX_WINDOW) ? int'(MAX_WINDOW) : int'(cfg_window);
		base  = int'(sw_base);
		nxt   = int'(sw_next);
		total = int'(sw_total);
		if (nxt < base + 1)
			nxt = base + 1;
		while (step_orders.size() < int'(MAX_WINDOW) && nxt <= total && nxt - base <= win) begin
			push_order((nxt == total) ? KIND_FINAL : KIND_DATA, nxt);
			nxt++;
		end
		sw_next = (SEQ_W+1)'(nxt);
	endfunction

	// Work out the send orders one accepted event causes
	function void window_step(net_evt_t ev);
		int segs;
		step_orders.delete();
		case (ev.op)
			OP_START: begin
				segs = (int'(ev.size) + CHUNK_BYTES - 1) / CHUNK_BYTES;
				if (segs > int'(SEG_MAX))
					segs = int'(SEG_MAX);
				sw_total   = SEG_W'(segs);
				sw_base    = '1;
				sw_next    = '0;
				sw_retries = '0;
				sw_active  = 1'b1;
				emit_window();
			end
			OP_ACK: begin
				if (sw_active) begin
					sw_retries = '0;
					if (ev.term) begin
						sw_active = 1'b0;
						push_order(KIND_DONE, 0);
					end else begin
						if (int'(ev.ack) > int'(sw_base))
							sw_base = (SEQ_W+1)'(ev.ack);
						emit_window();
					end
				end
			end
			OP_TIMEOUT: begin
				if (sw_active) begin
					if (sw_retries >= cfg_max_retries) begin
						sw_active = 1'b0;
						push_order(KIND_ABORT, 0);
					end else begin
						sw_next = sw_base + (SEQ_W+1)'(1);
						emit_window();
						if (sw_retries != RETRY_SAT)
							sw_retries++;
					end
				end
			end
			default: ;
		endcase
		if (step_orders.size() > 0)
			step_orders[step_orders.size() - 1].is_last = 1'b1;
		foreach (step_orders[i])
			pending_orders.push_back(step_orders[i]);
	endfunction

	// Event driver: bursts of random length with random gaps
	net_evt_t drv_evt;
	int       burst_left = 0;
	int       gap_left   = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				window_step(drv_evt);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (event_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else begin
					drv_evt = event_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {drv_evt.ack, drv_evt.size};
					s_tuser  <= {drv_evt.term, drv_evt.op};
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 15);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// Send order monitor and receiver stalls
	rx_mode_t    stall_mode   = RX_FREE;
	int          stall_span   = 0;
	int          stall_period = 2;
	int          stall_tick   = 0;
	send_order_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_orders.size() == 0) begin
					report_mismatch($sformatf("unexpected beat kind %0d segment %0d last %0b",
						m_tuser, m_tdata, m_tlast));
				end else begin
					want = pending_orders.pop_front();
					if (m_tuser !== want.kind)
						report_mismatch($sformatf("kind %0d, expected %s (segment %0d)",
							m_tuser, want.kind.name(), want.seg));
					if (m_tdata !== want.seg)
						report_mismatch($sformatf("segment %0d, expected %0d",
							m_tdata, want.seg));
					if (m_tlast !== want.is_last)
						report_mismatch($sformatf("tlast %0b, expected %0b (segment %0d)",
							m_tlast, want.is_last, want.seg));
				end
			end
			if (stall_span == 0) begin
				stall_mode   = rx_mode_t'($urandom_range(0, 2));
				stall_span   = $urandom_range(32, 160);
				stall_period = $urandom_range(2, 6);
			end else begin
				stall_span--;
			end
			stall_tick++;
			case (stall_mode)
				RX_FREE:   m_tready <= 1'b1;
				RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
				default:   m_tready <= (stall_tick % stall_period == 0);
			endcase
		end
	end

	// Stimulus helpers
	task add_event(op_t op, int unsigned size, int unsigned ack, bit term);
		net_evt_t ev;
		ev.op   = op;
		ev.size = size[SIZE_W-1:0];
		ev.ack  = ack[SEG_W-1:0];
		ev.term = term;
		event_q.push_back(ev);
	endtask

	// A plausible transfer: start, acks creeping forward, timeouts, then an ending or none
	task add_transfer();
		int size;
		int segs;
		int acked;
		int span;
		if ($urandom_range(0, 9) == 0)
			size = $urandom_range(0, 24'hFFFFFF);
		else
			size = $urandom_range(0, 24 * CHUNK_BYTES);
		segs  = (size + CHUNK_BYTES - 1) / CHUNK_BYTES;
		span  = int'(cfg_window) + 1;
		acked = -1;
		add_event(OP_START, size, $urandom, 1'($urandom_range(0, 1)));
		repeat ($urandom_range(2, 14)) begin
			case ($urandom_range(0, 5))
				0: add_event(OP_TIMEOUT, $urandom, $urandom, 1'($urandom_range(0, 1)));
				1: add_event(OP_ACK, $urandom, (acked < 0) ? 0 : acked, 1'b0);
				default: begin
					acked += $urandom_range(1, span);
					if (acked > segs + 1)
						acked = segs + 1;
					add_event(OP_ACK, $urandom, acked, 1'b0);
				end
			endcase
		end
		case ($urandom_range(0, 3))
			0, 1: add_event(OP_ACK, $urandom, $urandom, 1'b1);
			2: begin
				repeat (int'(cfg_max_retries) + 1)
					add_event(OP_TIMEOUT, $urandom, $urandom, 1'($urandom_range(0, 1)));
			end
			default: ; // left open, the next start restarts it
		endcase
	endtask

	// Anything goes: every op, every field value
	task add_noise();
		repeat ($urandom_range(1, 4))
			add_event(op_t'($urandom_range(0, 3)), $urandom, $urandom,
				1'($urandom_range(0, 1)));
	endtask

	// Hold off until every queued event has gone and every send order has come
	task wait_quiet();
		int guard;
		guard = 0;
		@(negedge clk);
		while ((event_q.size() != 0 || s_tvalid || pending_orders.size() != 0)
				&& guard < QUIET_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_WINDOW_SIZE: cfg_window      = value;
			REG_MAX_RETRIES: cfg_max_retries = value[RETRY_W-1:0];
			default: ;
		endcase
	endtask

	// Main sequence
	initial begin
		int q_mark;
		int phase_items;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset settings: window 10, retries 10
		add_event(OP_ACK, 0, 16'hFFFF, 1'b1);          // ack while idle
		add_event(OP_TIMEOUT, 0, 0, 1'b0);             // timeout while idle
		add_event(OP_UNUSED, 24'hFFFFFF, 16'hFFFF, 1'b1);
		add_event(OP_START, 0, 0, 1'b0);               // empty file: final 0 only
		add_event(OP_ACK, 0, 0, 1'b0);                 // ack of the final segment
		add_event(OP_ACK, 0, 0, 1'b1);                 // terminal ack
		add_event(OP_START, 1000, 0, 1'b0);
		add_event(OP_START, 24'hFFFFFF, 0, 1'b0);      // restart while active, largest file
		add_event(OP_ACK, 0, 5, 1'b0);
		add_event(OP_ACK, 0, 2, 1'b0);                 // stale ack
		add_event(OP_ACK, 0, 40, 1'b0);                // ack past the next segment to send
		add_event(OP_TIMEOUT, 0, 0, 1'b0);
		add_event(OP_ACK, 0, 16'hFFFF, 1'b0);          // ack past the final segment
		add_event(OP_TIMEOUT, 0, 0, 1'b0);
		add_event(OP_ACK, 0, 0, 1'b1);
		add_event(OP_START, 3 * CHUNK_BYTES, 0, 1'b0);
		repeat (int'(RETRIES_RESET) + 1)
			add_event(OP_TIMEOUT, 0, 0, 1'b0);         // runs out of retries and aborts

		// Random phases, each on its own register settings
		for (int p = 0; p < PHASES; p++) begin
			wait_quiet();
			if (p == PHASES - 1) begin
				write_reg(REG_WINDOW_SIZE, CFG_DATA_W'($urandom_range(1, 16)));
				write_reg(REG_MAX_RETRIES, CFG_DATA_W'($urandom_range(1, 15)));
			end else begin
				write_reg(REG_WINDOW_SIZE, WIN_PLAN[p*CFG_DATA_W +: CFG_DATA_W]);
				write_reg(REG_MAX_RETRIES, RETRY_PLAN[p*CFG_DATA_W +: CFG_DATA_W]);
			end
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				if ($urandom_range(0, 6) == 0) begin
					add_noise();
				end else begin
					q_mark = event_q.size();
					add_transfer();
					phase_items += event_q.size() - q_mark;
				end
			end
		end

		wait_quiet();
		if (pending_orders.size() != 0)
			report_mismatch($sformatf("%0d send orders never arrived", pending_orders.size()));
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/gbn_pkg.sv
rtl/core/gbn_cfg.sv
rtl/core/gbn_ctrl.sv
rtl/core/gbn_dp.sv
rtl/core/go_back_n_sender_window.sv
tb/testbench.sv
